// File: src/jese_pkg.sv
// ----------------------------------------------------------------------------
// jese_pkg - shared types and constants
// Sizes, successor table access beat and result record for the eliminator.
// ----------------------------------------------------------------------------
package jese_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int POS_W         = $clog2(MAX_POSITIONS);
    localparam int CNT_W         = POS_W + 1;
    localparam int RING_W        = 11;   // ring_size register width
    localparam int FIELD_W       = 11;   // removed_position width

    typedef struct packed {
        logic             en;
        logic             we;
        logic [POS_W-1:0] addr;
        logic [POS_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] pos;
        logic               final_one;
        logic               exhausted;
    } result_t;

endpackage

// File: src/josephus_every_second_eliminator.sv
// ----------------------------------------------------------------------------
// josephus_every_second_eliminator - every-second Josephus elimination
// Linked ring of successors in a single-port table, one removal per request.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat fields (lowest bit first)
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tdata[0] restart
//  m_axis    out  tdata[10:0] removed_position, tlast final_one,
//                 tuser exhausted
//  cfg       in   data[10:0] ring_size (always ready)
//
//  A removal uses the table's single port for two dependent successor
//  reads and one write-back. Final and exhausted requests touch no table
//  entry; a restart writes one table entry per position (ring_size
//  capped at 1024). Reset leaves the ring empty (requests report
//  exhausted) and ring_size at 1. A new beat is taken while a result
//  waits in the output register; the sequencer stalls only when its own
//  result finds that register still full.
//
module josephus_every_second_eliminator
    import jese_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [10:0] removed_position
    output logic        m_axis_tlast,   // final_one
    output logic        m_axis_tuser,   // exhausted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data        // [10:0] ring_size
);

    logic [RING_W-1:0]  ring_size_reg;
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_pos_reg;
    logic               out_final_reg;
    logic               out_exh_reg;

    logic               slot_free;
    result_t            res;
    ram_req_t           ram_req;
    logic [POS_W-1:0]   ram_rdata;

    // output register is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    jese_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .restart   (s_axis_tdata[0]),
        .ring_size (ring_size_reg),
        .slot_free (slot_free),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    jese_succ_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // ring_size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= RING_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            ring_size_reg <= cfg_data;
        end
    end

    // output register: valid under reset, payload loads with each result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_pos_reg   <= res.pos;
            out_final_reg <= res.final_one;
            out_exh_reg   <= res.exhausted;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - FIELD_W){1'b0}}, out_pos_reg};
    assign m_axis_tlast  = out_final_reg;
    assign m_axis_tuser  = out_exh_reg;

endmodule

// File: src/jese_succ_ram.sv
// ----------------------------------------------------------------------------
// jese_succ_ram - successor table
// Single-port table, one read or one write per cycle, registered read data.
// ----------------------------------------------------------------------------
module jese_succ_ram
    import jese_pkg::*;
(
    input  logic             clk,
    input  ram_req_t         req,
    output logic [POS_W-1:0] rdata
);

    logic [POS_W-1:0] mem [MAX_POSITIONS];
    logic [POS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/jese_seq.sv
// ----------------------------------------------------------------------------
// jese_seq - elimination sequencer
// Drives the table port: ring rebuild sweep and the read-read-write removal.
// ----------------------------------------------------------------------------
module jese_seq
    import jese_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              restart,
    input  logic [RING_W-1:0] ring_size,
    input  logic              slot_free,
    output result_t           res,
    output ram_req_t          ram_req,
    input  logic [POS_W-1:0]  ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_VICTIM,
        S_NEXT,
        S_HOLD,
        S_BUILD
    } state_t;

    state_t           state_reg,  state_next;
    logic [POS_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [POS_W-1:0] idx_reg,    idx_next;
    logic [CNT_W-1:0] n_reg,      n_next;
    logic [POS_W-1:0] victim_reg, victim_next;
    result_t          pend_reg,   pend_next;

    logic [CNT_W-1:0] n_sat;
    logic             build_last;
    logic             accept;
    result_t          removal;

    always_comb
    begin
        if (32'(ring_size) > 32'(MAX_POSITIONS))
            n_sat = CNT_W'(MAX_POSITIONS);
        else
            n_sat = CNT_W'(ring_size);
    end

    assign build_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_reg);
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        removal.valid     = 1'b1;
        removal.pos       = FIELD_W'(CNT_W'(victim_reg) + CNT_W'(1));
        removal.final_one = 1'b0;
        removal.exhausted = 1'b0;
    end

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        victim_next = victim_reg;
        pend_next   = pend_reg;
        ram_req     = '0;
        res         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        cursor_next = '0;
                        count_next  = n_sat;
                        n_next      = n_sat;
                        idx_next    = '0;
                        if (n_sat != '0)
                            state_next = S_BUILD;
                    end
                    else if (count_reg == '0)
                    begin
                        pend_next.valid     = 1'b1;
                        pend_next.pos       = '0;
                        pend_next.final_one = 1'b0;
                        pend_next.exhausted = 1'b1;
                        state_next          = S_HOLD;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        pend_next.valid     = 1'b1;
                        pend_next.pos       = FIELD_W'(CNT_W'(cursor_reg) + CNT_W'(1));
                        pend_next.final_one = 1'b1;
                        pend_next.exhausted = 1'b0;
                        count_next          = '0;
                        state_next          = S_HOLD;
                    end
                    else
                    begin
                        ram_req.en   = 1'b1;
                        ram_req.addr = cursor_reg;
                        state_next   = S_VICTIM;
                    end
                end
            end
            S_VICTIM:
            begin
                victim_next  = ram_rdata;
                ram_req.en   = 1'b1;
                ram_req.addr = ram_rdata;
                state_next   = S_NEXT;
            end
            S_NEXT:
            begin
                // unlink the victim: cursor now points past it
                ram_req.en    = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.addr  = cursor_reg;
                ram_req.wdata = ram_rdata;
                cursor_next   = ram_rdata;
                count_next    = count_reg - CNT_W'(1);
                if (slot_free)
                begin
                    res        = removal;
                    state_next = S_IDLE;
                end
                else
                begin
                    pend_next  = removal;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    res        = pend_reg;
                    state_next = S_IDLE;
                end
            end
            S_BUILD:
            begin
                ram_req.en    = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.addr  = idx_reg;
                ram_req.wdata = build_last ? '0 : POS_W'(CNT_W'(idx_reg) + CNT_W'(1));
                idx_next      = POS_W'(CNT_W'(idx_reg) + CNT_W'(1));
                if (build_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            n_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            n_reg      <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        victim_reg <= victim_next;
        pend_reg   <= pend_next;
    end

    a_build_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD) |-> (CNT_W'(idx_reg) < n_reg))
        else $error("rebuild sweep beyond ring size");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POSITIONS))
        else $error("remaining count above table depth");

    a_removal_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEXT) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not shrink the ring by one");

    a_exhausted_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.exhausted) |-> (res.pos == '0 && !res.final_one))
        else $error("exhausted result carries a position");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - bench for the every-second Josephus eliminator
// Streams restart and removal beats with random gaps and output stalls, keeps
// its own copy of the successor ring and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;

    import jese_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 400;
    localparam int REPORT_MAX   = 10;

    // one result beat as the checker sees it
    typedef struct packed {
        logic [FIELD_W-1:0] pos;
        logic               final_one;
        logic               exhausted;
    } removal_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [10:0] removed_position
    logic        m_axis_tlast;          // final_one
    logic        m_axis_tuser;          // exhausted
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data      = '0;    // [10:0] ring_size

    // stimulus side
    bit          request_queue[$];      // 1 = restart, 0 = removal request
    int          src_gap       = 0;
    int          sink_gap      = 0;
    bit          src_calm      = 1'b0;  // no source gaps in this stretch
    bit          sink_calm     = 1'b0;  // no output stalls in this stretch
    int          cfg_value     = 0;
    int          cfg_asked     = 0;
    int          cfg_sent      = 0;
    int          cfg_done      = 0;

    // ring as the bench predicts it
    logic [POS_W-1:0]  succ_tab [MAX_POSITIONS];
    logic [POS_W-1:0]  ring_cursor;
    logic [CNT_W-1:0]  ring_left;
    logic [RING_W-1:0] ring_size_reg;
    removal_t          removals_due[$];

    // bookkeeping
    int cycle_count    = 0;
    int flaw_count     = 0;
    int beats_checked  = 0;
    int finals_seen    = 0;
    int exhausts_seen  = 0;
    int rebuilds       = 0;
    int requests_sent  = 0;
    int random_items   = 0;

    josephus_every_second_eliminator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // restart: link positions 0..n-1 into a circle, cursor on the first
    task automatic rebuild_ring();
        int n;
        n = (ring_size_reg > MAX_POSITIONS) ? MAX_POSITIONS : int'(ring_size_reg);
        for (int i = 0; i < n; i++)
            succ_tab[i] = (i + 1 < n) ? POS_W'(i + 1) : '0;
        ring_cursor = '0;
        ring_left   = CNT_W'(n);
    endtask

    // request: drop the position after the cursor and step past it, or report the last one or exhausted
    task automatic eliminate_next();
        removal_t         r;
        logic [POS_W-1:0] victim;
        logic [POS_W-1:0] nxt;
        r = '0;
        if (ring_left == 0)
        begin
            r.exhausted = 1'b1;
        end
        else if (ring_left == 1)
        begin
            // lone survivor goes itself
            r.pos       = FIELD_W'(ring_cursor) + FIELD_W'(1);
            r.final_one = 1'b1;
            ring_left   = '0;
        end
        else
        begin
            victim                = succ_tab[ring_cursor];
            nxt                   = succ_tab[victim];
            succ_tab[ring_cursor] = nxt;
            ring_cursor           = nxt;
            ring_left             = ring_left - 1'b1;
            r.pos                 = FIELD_W'(victim) + FIELD_W'(1);
        end
        removals_due.push_back(r);
    endtask

    // source side: request beats plus the ring_size write channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
            cfg_valid     <= 1'b0;
            cfg_data      <= '0;
            cfg_sent      <= 0;
        end
        else
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap != 0)
                begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, request_queue.pop_front()};
                    src_gap       <= pick_gap(src_calm);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_valid <= 1'b0;
            end
            else if (!cfg_valid && cfg_sent != cfg_asked)
            begin
                cfg_valid <= 1'b1;
                cfg_data  <= cfg_value[10:0];
                cfg_sent  <= cfg_sent + 1;
            end
        end
    end

    // sink side: random back-pressure, started after a beat or out of the blue
    always @(posedge clk or negedge rst_n)
    begin : sink_side
        int stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end
        else
        begin
            stall = 0;
            if (m_axis_tvalid && m_axis_tready)
                stall = pick_gap(sink_calm);
            else if ($urandom_range(19) == 0)
                stall = pick_gap(sink_calm);
            if (sink_gap != 0)
            begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall != 0)
            begin
                sink_gap      <= stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: check result beats, then fold accepted beats into the ring copy
    always @(posedge clk or negedge rst_n)
    begin : monitor
        removal_t got;
        removal_t want;
        if (!rst_n)
        begin
            ring_size_reg = RING_W'(1);
            ring_cursor   = '0;
            ring_left     = '0;
        end
        else
        begin
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results still due",
                         cycle_count, removals_due.size());
                $display("FAIL josephus_every_second_eliminator");
                $finish;
            end
            else
            begin
                if (m_axis_tvalid && m_axis_tready)
                begin
                    got.pos       = m_axis_tdata[FIELD_W-1:0];
                    got.final_one = m_axis_tlast;
                    got.exhausted = m_axis_tuser;
                    if (removals_due.size() == 0)
                    begin
                        flaw_count++;
                        if (flaw_count <= REPORT_MAX)
                            $display("%0t: stray result beat pos %0d final %b exhausted %b",
                                     $realtime, got.pos, got.final_one, got.exhausted);
                    end
                    else
                    begin
                        want = removals_due.pop_front();
                        beats_checked++;
                        if (want.final_one)
                            finals_seen++;
                        if (want.exhausted)
                            exhausts_seen++;
                        if (got !== want)
                        begin
                            flaw_count++;
                            if (flaw_count <= REPORT_MAX)
                                $display("%0t: result %0d: expected pos %0d final %b ",
                                         $realtime, beats_checked, want.pos,
                                         want.final_one,
                                         "exhausted %b, got pos %0d final %b exhausted %b",
                                         want.exhausted, got.pos, got.final_one,
                                         got.exhausted);
                        end
                    end
                end
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (s_axis_tdata[0])
                    begin
                        rebuild_ring();
                        rebuilds++;
                    end
                    else
                    begin
                        eliminate_next();
                    end
                end
                if (cfg_valid && cfg_ready)
                begin
                    ring_size_reg = cfg_data;
                    cfg_done++;
                end
            end
        end
    end

    task automatic send(bit restart, int count);
        repeat (count)
            request_queue.push_back(restart);
        if (!restart)
            requests_sent += count;
    endtask

    // all beats in, all results out, then let a rebuild run to its end
    task automatic wait_idle();
        int settle;
        do
            @(negedge clk);
        while (request_queue.size() != 0 || s_axis_tvalid || removals_due.size() != 0);
        settle = (ring_size_reg > MAX_POSITIONS) ? MAX_POSITIONS : int'(ring_size_reg);
        repeat (settle + 12) @(negedge clk);
    endtask

    task automatic write_ring_size(int v);
        wait_idle();
        cfg_value = v;
        cfg_asked++;
        do
            @(negedge clk);
        while (cfg_done != cfg_asked);
    endtask

    initial
    begin : stimulus
        int v;
        int eff;
        int k;
        int roll;
        @(posedge rst_n);
        @(negedge clk);

        // directed opening
        send(0, 1);                     // request before any restart
        send(1, 1);                     // reset ring_size of one
        send(0, 2);                     // lone survivor, then exhausted
        write_ring_size(0);             // empty ring
        send(1, 1);
        send(0, 1);
        write_ring_size(2);
        send(1, 1);
        send(0, 3);
        write_ring_size(2047);          // saturates to the table depth
        send(1, 1);
        send(0, 3);
        write_ring_size(5);             // restart in the middle of a ring
        send(1, 1);
        send(0, 2);
        send(1, 1);
        send(0, 6);

        // random phases
        while (random_items < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                v = $urandom_range(1, 12);
            else if (roll < 75)
                v = $urandom_range(13, 64);
            else if (roll < 85)
                v = $urandom_range(65, 300);
            else if (roll < 90)
                v = 0;
            else if (roll < 95)
                v = MAX_POSITIONS;
            else
                v = $urandom_range(MAX_POSITIONS + 1, 2047);
            if ($urandom_range(9) < 8)
                write_ring_size(v);
            src_calm  = ($urandom_range(9) < 3);
            sink_calm = ($urandom_range(9) < 3);
            eff = (ring_size_reg > MAX_POSITIONS) ? MAX_POSITIONS : int'(ring_size_reg);

            roll = $urandom_range(99);
            if (roll < 75)
            begin
                // clean run: rebuild, then eliminate; small rings to (past) the end
                k = (eff <= 60) ? eff + $urandom_range(0, 2) : $urandom_range(20, 70);
                send(1, 1);
                send(0, k);
                random_items += k + 1;
            end
            else if (roll < 90)
            begin
                // run cut short by a second restart
                k = $urandom_range(0, (eff < 40) ? eff : 40);
                send(1, 1);
                send(0, k);
                send(1, 1);
                k = (eff <= 40) ? eff + $urandom_range(0, 1) : $urandom_range(5, 40);
                send(0, k);
                random_items += 2 + k;
            end
            else
            begin
                // loose mix
                k = $urandom_range(1, 12);
                repeat (k)
                    send($urandom_range(4) == 0, 1);
                random_items += k;
            end
        end

        wait_idle();
        $display("sent %0d removal requests and %0d ring rebuilds across %0d size writes",
                 requests_sent, rebuilds, cfg_done);
        $display("checked %0d results: %0d final removals, %0d exhausted replies, %0d faults",
                 beats_checked, finals_seen, exhausts_seen, flaw_count);
        if (flaw_count == 0 && removals_due.size() == 0)
            $display("PASS josephus_every_second_eliminator");
        else
            $display("FAIL josephus_every_second_eliminator");
        $finish;
    end

endmodule

// File: sim.f
src/jese_pkg.sv
src/jese_succ_ram.sv
src/jese_seq.sv
src/josephus_every_second_eliminator.sv
bench/tb_top.sv
